### rtl/core/ppag_pkg.sv
// ppag_pkg: shared widths, constants and payload types for the pixel
// accumulation and gamma pack core. No dependencies.
// Used by every module under rtl/core.
package ppag_pkg;

  // field widths
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int SAMPLE_W = 12;
  localparam int WIDTH_W  = 11;
  localparam int COLOUR_W = 16;
  localparam int INDEX_W  = 16;
  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int CHANNELS = 3;

  // store address width; the store holds 2**PIXEL_ADDR_W pixels
  localparam int PIXEL_ADDR_W = 16;

  // colour format and gamma scaling
  localparam int COLOUR_FRACTION_BITS = 12;
  localparam int SCALE_SHIFT = COLOUR_W - COLOUR_FRACTION_BITS;
  localparam int SCALED_W    = COLOUR_W + BYTE_W;

  // running mean arithmetic: (old * s + new) / (s + 1)
  localparam int DIVISOR_W  = SAMPLE_W + 1;
  localparam int DIVIDEND_W = COLOUR_W + SAMPLE_W;
  localparam int REM_W      = DIVISOR_W;

  // constants
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(256);
  localparam logic [BYTE_W-1:0]  ALPHA       = 8'hFF;
  localparam logic [BYTE_W-1:0]  BYTE_MAX    = 8'hFF;

  // channel order inside a packed colour: red high, blue low
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef logic [CHANNELS-1:0][COLOUR_W-1:0]   rgb_t;
  typedef logic [CHANNELS-1:0][DIVIDEND_W-1:0] dividend_t;

endpackage

### rtl/core/ppag_store.sv
// ppag_store: mean colour store, one write port and one registered read port.
// Depends on ppag_pkg for the colour type.
// Contents are undefined until written.
module ppag_store #(
  parameter int ADDR_W = ppag_pkg::PIXEL_ADDR_W
) (
  input  logic               clk,
  input  logic [ADDR_W-1:0]  rd_addr,
  output ppag_pkg::rgb_t     rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  ppag_pkg::rgb_t     wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  ppag_pkg::rgb_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/ppag_divider.sv
// ppag_divider: pipelined restoring divider for the three colour channels.
// Depends on ppag_pkg. Four register stages, four quotient bits per stage;
// the quotient is known to fit in COLOUR_W bits.
module ppag_divider (
  input  logic                              clk,
  input  ppag_pkg::dividend_t               dividend,
  input  logic [ppag_pkg::DIVISOR_W-1:0]    divisor,
  output ppag_pkg::rgb_t                    quotient
);

  localparam int STAGES = 4;
  localparam int STEPS  = ppag_pkg::COLOUR_W / STAGES;

  typedef struct packed {
    logic [ppag_pkg::REM_W-1:0]    rem;
    logic [ppag_pkg::COLOUR_W-1:0] work;
  } lane_t;

  // one restoring step: shift in a dividend bit, shift out a quotient bit
  function automatic lane_t div_step(lane_t x, logic [ppag_pkg::DIVISOR_W-1:0] d);
    logic [ppag_pkg::REM_W:0] cand;
    logic [ppag_pkg::REM_W:0] dext;
    logic                     qbit;
    lane_t                    y;
    cand = {x.rem, x.work[ppag_pkg::COLOUR_W-1]};
    dext = {1'b0, d};
    qbit = (cand >= dext);
    if (qbit) begin
      y.rem = ppag_pkg::REM_W'(cand - dext);
    end else begin
      y.rem = cand[ppag_pkg::REM_W-1:0];
    end
    y.work = {x.work[ppag_pkg::COLOUR_W-2:0], qbit};
    return y;
  endfunction

  lane_t                          lane_in [STAGES][ppag_pkg::CHANNELS];
  lane_t                          lane_nx [STAGES][ppag_pkg::CHANNELS];
  lane_t                          lane_q  [STAGES][ppag_pkg::CHANNELS];
  logic [ppag_pkg::DIVISOR_W-1:0] div_in  [STAGES];
  logic [ppag_pkg::DIVISOR_W-1:0] div_q   [STAGES];

  // stage inputs: first stage splits the dividend, later ones take the previous stage
  always_comb begin
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      lane_in[0][ch].rem  =
        ppag_pkg::REM_W'(dividend[ch][ppag_pkg::DIVIDEND_W-1:ppag_pkg::COLOUR_W]);
      lane_in[0][ch].work = dividend[ch][ppag_pkg::COLOUR_W-1:0];
      for (int st = 1; st < STAGES; st++) begin
        lane_in[st][ch] = lane_q[st-1][ch];
      end
    end
    div_in[0] = divisor;
    for (int st = 1; st < STAGES; st++) begin
      div_in[st] = div_q[st-1];
    end
  end

  // steps of each stage
  always_comb begin
    lane_t t;
    for (int st = 0; st < STAGES; st++) begin
      for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
        t = lane_in[st][ch];
        for (int k = 0; k < STEPS; k++) begin
          t = div_step(t, div_in[st]);
        end
        lane_nx[st][ch] = t;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    lane_q <= lane_nx;
    div_q  <= div_in;
  end

  always_comb begin
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      quotient[ch] = lane_q[STAGES-1][ch].work;
    end
  end

endmodule

### rtl/core/ppag_gamma.sv
// ppag_gamma: gamma 2 (integer square root), saturation and ARGB8888 packing.
// Depends on ppag_pkg. Two register stages, four root bits per stage;
// the packed word is registered at the output.
module ppag_gamma (
  input  logic                         clk,
  input  ppag_pkg::rgb_t               colour,
  output logic [ppag_pkg::WORD_W-1:0]  argb_word
);

  localparam int SQ_REM_W = 11;
  localparam int HALF_W   = ppag_pkg::COLOUR_W / 2;
  localparam int PAIRS    = HALF_W / 2;

  typedef struct packed {
    logic [SQ_REM_W-1:0]         rem;
    logic [ppag_pkg::BYTE_W-1:0] root;
  } sq_t;

  // one digit of the bitwise square root
  function automatic sq_t sq_step(sq_t x, logic [1:0] pair);
    logic [SQ_REM_W-1:0] cand;
    logic [SQ_REM_W-1:0] trial;
    sq_t                 y;
    cand  = SQ_REM_W'({x.rem, pair});
    trial = SQ_REM_W'({x.root, 2'b01});
    if (cand >= trial) begin
      y.rem  = cand - trial;
      y.root = {x.root[ppag_pkg::BYTE_W-2:0], 1'b1};
    end else begin
      y.rem  = cand;
      y.root = {x.root[ppag_pkg::BYTE_W-2:0], 1'b0};
    end
    return y;
  endfunction

  sq_t                 hi_nx  [ppag_pkg::CHANNELS];
  sq_t                 hi_q   [ppag_pkg::CHANNELS];
  logic [HALF_W-1:0]   low_nx [ppag_pkg::CHANNELS];
  logic [HALF_W-1:0]   low_q  [ppag_pkg::CHANNELS];
  logic [ppag_pkg::CHANNELS-1:0] sat_nx;
  logic [ppag_pkg::CHANNELS-1:0] sat_q;
  logic [ppag_pkg::CHANNELS-1:0][ppag_pkg::BYTE_W-1:0] bytes;

  // first half: scale, detect saturation, upper root bits
  always_comb begin
    logic [ppag_pkg::SCALED_W-1:0] scaled;
    sq_t                           s;
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      scaled     = ppag_pkg::SCALED_W'(colour[ch]) << ppag_pkg::SCALE_SHIFT;
      sat_nx[ch] = |scaled[ppag_pkg::SCALED_W-1:ppag_pkg::COLOUR_W];
      s          = '0;
      for (int i = 0; i < PAIRS; i++) begin
        s = sq_step(s, scaled[ppag_pkg::COLOUR_W-1-2*i -: 2]);
      end
      hi_nx[ch]  = s;
      low_nx[ch] = scaled[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    hi_q  <= hi_nx;
    low_q <= low_nx;
    sat_q <= sat_nx;
  end

  // second half: lower root bits and clamp
  always_comb begin
    sq_t s;
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      s = hi_q[ch];
      for (int i = 0; i < PAIRS; i++) begin
        s = sq_step(s, low_q[ch][HALF_W-1-2*i -: 2]);
      end
      bytes[ch] = sat_q[ch] ? ppag_pkg::BYTE_MAX : s.root;
    end
  end

  // pack alpha, red, green, blue
  always_ff @(posedge clk) begin
    argb_word <= {ppag_pkg::ALPHA, bytes[ppag_pkg::CH_RED], bytes[ppag_pkg::CH_GREEN],
                  bytes[ppag_pkg::CH_BLUE]};
  end

endmodule

### rtl/core/progressive_pixel_average_gamma_pack_core.sv
// progressive_pixel_average_gamma_pack_core: per-pixel running mean of colour
// samples kept in a memory, with gamma 2 correction and ARGB8888 output.
// Depends on ppag_pkg, ppag_store, ppag_divider and ppag_gamma.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  sample   | start / busy         | row, column, sample_number, red/green/blue_in
//  result   | done (1-cycle strobe)| pixel_index, argb_word
//  config   | cfg_write            | cfg_data (line pitch)
//
// One sample is taken per cycle unless busy; results leave in order. A nonzero
// sample number aimed at a pixel still in the read-modify-write loop (the seven
// stages from store read through multiplier and divider to write back) stalls the
// issue stage until that pixel is written back (busy if the input stage is full
// too). Reset clears control state and sets the line pitch to 256; the store is
// not cleared and needs no clearing pass. The result side has no backpressure.
module progressive_pixel_average_gamma_pack_core #(
  parameter int ADDR_W = ppag_pkg::PIXEL_ADDR_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ppag_pkg::ROW_W-1:0]      row,
  input  logic [ppag_pkg::COL_W-1:0]      column,
  input  logic [ppag_pkg::SAMPLE_W-1:0]   sample_number,
  input  logic [ppag_pkg::COLOUR_W-1:0]   red_in,
  input  logic [ppag_pkg::COLOUR_W-1:0]   green_in,
  input  logic [ppag_pkg::COLOUR_W-1:0]   blue_in,
  output logic                            done,
  output logic [ppag_pkg::INDEX_W-1:0]    pixel_index,
  output logic [ppag_pkg::WORD_W-1:0]     argb_word,
  input  logic                            cfg_write,
  input  logic [ppag_pkg::WIDTH_W-1:0]    cfg_data
);

  localparam int LIN_W       = ppag_pkg::ROW_W + ppag_pkg::WIDTH_W + 1;
  localparam int TRACK_DEPTH = 9;
  localparam int WRITE_SLOT  = 6;
  localparam int OUT_SLOT    = TRACK_DEPTH - 1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
  } slot_t;

  logic [ppag_pkg::WIDTH_W-1:0] line_pitch;

  logic                           accept;
  logic                           a_valid;
  logic                           a_hold;
  logic [ppag_pkg::ROW_W-1:0]     a_row;
  logic [ppag_pkg::COL_W-1:0]     a_col;
  logic [ppag_pkg::SAMPLE_W-1:0]  a_s;
  ppag_pkg::rgb_t                 a_rgb;
  logic [LIN_W-1:0]               a_lin;

  logic                           b_valid;
  logic                           b_stall;
  logic                           b_go;
  logic                           b_hit;
  logic                           hazard;
  logic [ADDR_W-1:0]              b_idx;
  logic [ppag_pkg::SAMPLE_W-1:0]  b_s;
  ppag_pkg::rgb_t                 b_rgb;

  slot_t                          track [TRACK_DEPTH];

  ppag_pkg::rgb_t                 rd_data;
  logic [ppag_pkg::SAMPLE_W-1:0]  c_s;
  ppag_pkg::rgb_t                 c_new;
  ppag_pkg::dividend_t            c_prod;
  ppag_pkg::dividend_t            d_prod;
  ppag_pkg::rgb_t                 d_new;
  logic [ppag_pkg::DIVISOR_W-1:0] d_div;
  ppag_pkg::dividend_t            e_dividend;
  logic [ppag_pkg::DIVISOR_W-1:0] e_div;
  ppag_pkg::rgb_t                 quotient;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch <= ppag_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      line_pitch <= cfg_data;
    end
  end

  // input stage
  assign busy   = a_hold;
  assign accept = start && !busy;
  assign a_hold = a_valid && b_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_hold) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_row <= row;
      a_col <= column;
      a_s   <= sample_number;
      a_rgb <= {red_in, green_in, blue_in};
    end
  end

  // linear pixel index, wrapped to the store size
  assign a_lin = LIN_W'(a_row) * LIN_W'(line_pitch) + LIN_W'(a_col);

  // issue stage: waits while a dependent pixel is still in the loop
  always_comb begin
    b_hit = 1'b0;
    for (int k = 0; k <= WRITE_SLOT; k++) begin
      b_hit = b_hit || (track[k].valid && (track[k].idx == b_idx));
    end
  end

  assign hazard  = (b_s != '0) && b_hit;
  assign b_stall = b_valid && hazard;
  assign b_go    = b_valid && !hazard;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_stall) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall) begin
      b_idx <= a_lin[ADDR_W-1:0];
      b_s   <= a_s;
      b_rgb <= a_rgb;
    end
  end

  // in-flight tracking from store read to result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TRACK_DEPTH; k++) begin
        track[k].valid <= 1'b0;
      end
    end else begin
      track[0] <= '{valid: b_go, idx: b_idx};
      for (int k = 1; k < TRACK_DEPTH; k++) begin
        track[k] <= track[k-1];
      end
    end
  end

  ppag_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (b_idx),
    .rd_data (rd_data),
    .wr_en   (track[WRITE_SLOT].valid),
    .wr_addr (track[WRITE_SLOT].idx),
    .wr_data (quotient)
  );

  // read stage: old colour times sample number
  always_ff @(posedge clk) begin
    c_s   <= b_s;
    c_new <= b_rgb;
  end

  always_comb begin
    logic [ppag_pkg::COLOUR_W-1:0] old;
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      old        = (c_s == '0) ? '0 : rd_data[ch];
      c_prod[ch] = ppag_pkg::DIVIDEND_W'(old) * ppag_pkg::DIVIDEND_W'(c_s);
    end
  end

  always_ff @(posedge clk) begin
    d_prod <= c_prod;
    d_new  <= c_new;
    d_div  <= ppag_pkg::DIVISOR_W'(c_s) + ppag_pkg::DIVISOR_W'(1);
  end

  // add the new sample to form the dividend
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < ppag_pkg::CHANNELS; ch++) begin
      e_dividend[ch] <= d_prod[ch] + ppag_pkg::DIVIDEND_W'(d_new[ch]);
    end
    e_div <= d_div;
  end

  ppag_divider u_divider (
    .clk      (clk),
    .dividend (e_dividend),
    .divisor  (e_div),
    .quotient (quotient)
  );

  ppag_gamma u_gamma (
    .clk       (clk),
    .colour    (quotient),
    .argb_word (argb_word)
  );

  // result beat
  assign done        = track[OUT_SLOT].valid;
  assign pixel_index = ppag_pkg::INDEX_W'(track[OUT_SLOT].idx);

`ifndef NO_ASSERTIONS
  // busy only when both front stages are full and the issue stage waits
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> (a_valid && b_valid && hazard))
    else $error("busy without a stalled issue stage");

  // a waiting issue stage keeps its pixel
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    b_stall |=> (b_valid && $stable(b_idx)))
    else $error("issue stage lost its pixel while stalled");

  // a dependent read never meets a write to the same pixel
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_s != '0)) |->
      !(track[WRITE_SLOT].valid && (track[WRITE_SLOT].idx == b_idx)))
    else $error("read issued against a pending write");

  // the interlock clears once the loop has drained
  a_stall_bound: assert property (@(posedge clk) disable iff (rst)
    (b_stall && $past(b_stall, 1) && $past(b_stall, 2) && $past(b_stall, 3) &&
     $past(b_stall, 4) && $past(b_stall, 5) && $past(b_stall, 6)) |=> !b_stall)
    else $error("issue stage stalled longer than the update loop");
`endif

endmodule

### test/tb_top.sv
// tb_top: self-checking bench for progressive_pixel_average_gamma_pack_core.
// Needs ppag_pkg and the core; a built-in per-pixel mean and gamma predictor
// checks every pixel_index/argb_word beat against the block's results.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD = 12;
  localparam longint RUN_LIMIT_NS = 4_000_000;
  localparam int BEATS_PER_WIDTH = 265;
  localparam int SETTLE_CYCLES = 15;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_OPEN_PIXELS = 6;
  localparam int COUNT_MAX = (1 << ppag_pkg::SAMPLE_W) - 1;
  localparam int COORD_MAX = (1 << ppag_pkg::ROW_W) - 1;

  typedef struct packed {
    logic [ppag_pkg::ROW_W-1:0]    row;
    logic [ppag_pkg::COL_W-1:0]    column;
    logic [ppag_pkg::SAMPLE_W-1:0] count;
    ppag_pkg::rgb_t                colour;
  } sample_beat_t;

  typedef struct packed {
    logic [ppag_pkg::INDEX_W-1:0] index;
    logic [ppag_pkg::WORD_W-1:0]  word;
  } pixel_result_t;

  // a pixel being accumulated, with the sample number it takes next
  typedef struct {
    logic [ppag_pkg::ROW_W-1:0] row;
    logic [ppag_pkg::COL_W-1:0] column;
    int                         next_count;
  } open_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic [ppag_pkg::INDEX_W-1:0] pixel_index;
  logic [ppag_pkg::WORD_W-1:0]  argb_word;
  logic cfg_write = 1'b0;
  logic [ppag_pkg::WIDTH_W-1:0] cfg_data = '0;
  sample_beat_t cur_beat = '0;

  // predictor state
  ppag_pkg::rgb_t colour_mem [0:(1 << ppag_pkg::PIXEL_ADDR_W)-1];
  logic [ppag_pkg::WIDTH_W-1:0] model_width = ppag_pkg::WIDTH_RESET;

  // stimulus bookkeeping
  bit entry_written [0:(1 << ppag_pkg::PIXEL_ADDR_W)-1];
  sample_beat_t pending_beats[$];
  pixel_result_t expected_pixels[$];
  open_pixel_t open_pixels[$];
  logic beat_taken = 1'b0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int beats_queued = 0;
  int beats_accepted = 0;
  int results_checked = 0;
  int widths_seen = 0;
  int error_count = 0;

  progressive_pixel_average_gamma_pack_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .row           (cur_beat.row),
    .column        (cur_beat.column),
    .sample_number (cur_beat.count),
    .red_in        (cur_beat.colour[ppag_pkg::CH_RED]),
    .green_in      (cur_beat.colour[ppag_pkg::CH_GREEN]),
    .blue_in       (cur_beat.colour[ppag_pkg::CH_BLUE]),
    .done          (done),
    .pixel_index   (pixel_index),
    .argb_word     (argb_word),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // linear pixel address, wrapped to the store size
  function automatic logic [ppag_pkg::INDEX_W-1:0] pixel_of(
      logic [ppag_pkg::ROW_W-1:0] r, logic [ppag_pkg::COL_W-1:0] c,
      logic [ppag_pkg::WIDTH_W-1:0] w);
    logic [31:0] lin;
    lin = 32'(r) * 32'(w) + 32'(c);
    return lin[ppag_pkg::INDEX_W-1:0];
  endfunction

  // gamma 2: floor(sqrt(v scaled to 16 fraction bits)), clipped to a byte
  function automatic logic [7:0] gamma_byte_of(logic [ppag_pkg::COLOUR_W-1:0] v);
    int unsigned scaled;
    int unsigned root;
    int unsigned trial;
    scaled = int'(v) << ppag_pkg::SCALE_SHIFT;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return (root > 255) ? ppag_pkg::BYTE_MAX : root[7:0];
  endfunction

  // fold one sample into the pixel mean and form the display word
  function automatic pixel_result_t fold_sample(sample_beat_t beat);
    pixel_result_t res;
    logic [ppag_pkg::INDEX_W-1:0] idx;
    int unsigned old_v;
    int unsigned new_v;
    int unsigned n;
    idx = pixel_of(beat.row, beat.column, model_width);
    n = beat.count;
    for (int c = 0; c < ppag_pkg::CHANNELS; c++) begin
      old_v = colour_mem[idx][c];
      new_v = beat.colour[c];
      if (n == 0) colour_mem[idx][c] = beat.colour[c];
      else colour_mem[idx][c] = 16'((old_v * n + new_v) / (n + 1));
    end
    res.index = idx;
    res.word = {ppag_pkg::ALPHA,
                gamma_byte_of(colour_mem[idx][ppag_pkg::CH_RED]),
                gamma_byte_of(colour_mem[idx][ppag_pkg::CH_GREEN]),
                gamma_byte_of(colour_mem[idx][ppag_pkg::CH_BLUE])};
    return res;
  endfunction

  function automatic ppag_pkg::rgb_t rgb_of(logic [15:0] red, logic [15:0] green,
                                            logic [15:0] blue);
    ppag_pkg::rgb_t c;
    c[ppag_pkg::CH_RED] = red;
    c[ppag_pkg::CH_GREEN] = green;
    c[ppag_pkg::CH_BLUE] = blue;
    return c;
  endfunction

  // mostly uniform channels, with black, full scale and values around 1.0 mixed in
  function automatic ppag_pkg::rgb_t random_colour();
    ppag_pkg::rgb_t c;
    for (int k = 0; k < ppag_pkg::CHANNELS; k++) begin
      case ($urandom_range(0, 7))
        0: c[k] = 16'h0000;
        1: c[k] = 16'hFFFF;
        2: c[k] = 16'($urandom_range(16'h0F00, 16'h1100));
        default: c[k] = 16'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic queue_beat(logic [9:0] r, logic [9:0] c, int n, ppag_pkg::rgb_t colour);
    sample_beat_t beat;
    beat.row = r;
    beat.column = c;
    beat.count = n[ppag_pkg::SAMPLE_W-1:0];
    beat.colour = colour;
    if (n == 0) entry_written[pixel_of(r, c, model_width)] = 1'b1;
    pending_beats.push_back(beat);
    beats_queued++;
  endtask

  // mostly progressive accumulation on a few hot pixels, plus jumps and noise
  task automatic queue_random(int total);
    open_pixel_t px;
    logic [9:0] r;
    logic [9:0] c;
    int pick;
    int k;
    open_pixels.delete();
    for (int i = 0; i < total; i++) begin
      pick = $urandom_range(0, 99);
      if (open_pixels.size() == 0 || pick < 15) begin
        // new pixel starts with a fresh sample
        px.row = 10'($urandom_range(0, COORD_MAX));
        px.column = 10'($urandom_range(0, COORD_MAX));
        px.next_count = 1;
        if (open_pixels.size() >= MAX_OPEN_PIXELS)
          open_pixels.delete($urandom_range(0, open_pixels.size() - 1));
        open_pixels.push_back(px);
        queue_beat(px.row, px.column, 0, random_colour());
      end else if (pick < 70) begin
        // next sample in sequence
        k = $urandom_range(0, open_pixels.size() - 1);
        queue_beat(open_pixels[k].row, open_pixels[k].column, open_pixels[k].next_count,
                   random_colour());
        open_pixels[k].next_count = (open_pixels[k].next_count == COUNT_MAX) ? 1 :
                                    open_pixels[k].next_count + 1;
      end else if (pick < 85) begin
        // out-of-order sample number on a live pixel
        k = $urandom_range(0, open_pixels.size() - 1);
        queue_beat(open_pixels[k].row, open_pixels[k].column, $urandom_range(1, COUNT_MAX),
                   random_colour());
      end else begin
        // anywhere; unwritten pixels only get a first sample
        r = 10'($urandom_range(0, COORD_MAX));
        c = 10'($urandom_range(0, COORD_MAX));
        queue_beat(r, c, entry_written[pixel_of(r, c, model_width)] ?
                   $urandom_range(0, COUNT_MAX) : 0, random_colour());
      end
    end
  endtask

  task automatic wait_for_results();
    do @(negedge clk);
    while (beats_accepted != beats_queued || expected_pixels.size() != 0);
  endtask

  task automatic write_width(logic [ppag_pkg::WIDTH_W-1:0] w);
    cfg_data <= w;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    model_width = w;
    widths_seen++;
  endtask

  // driver: present the next beat at the falling edge, with idle bursts
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && !beat_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 9);
      end else if (pending_beats.size() != 0) begin
        cur_beat <= pending_beats.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // accepted beat: predict its result
  always @(posedge clk) begin
    beat_taken <= start && !busy && !rst;
    if (!rst && start && !busy) begin
      expected_pixels.push_back(fold_sample(cur_beat));
      beats_accepted++;
    end
  end

  // monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result: pixel_index %h argb_word %h",
                             pixel_index, argb_word));
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (pixel_index !== want.index)
          flag_error($sformatf("pixel_index expected %h got %h", want.index, pixel_index));
        if (argb_word !== want.word)
          flag_error($sformatf("argb_word expected %h got %h (pixel %h)",
                               want.word, argb_word, want.index));
      end
    end
  end

  // main sequence
  initial begin
    logic [ppag_pkg::WIDTH_W-1:0] widths [7];
    widths = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'($urandom_range(2, 1023)),
               11'd640, ppag_pkg::WIDTH_RESET};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners, saturation, index wrap, back-to-back updates of one pixel
    queue_beat(0, 0, 0, rgb_of(16'h0000, 16'h0000, 16'h0000));
    queue_beat(0, 0, 1, rgb_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_beat(0, 0, COUNT_MAX, rgb_of(16'hFFFF, 16'h0000, 16'h0001));
    queue_beat(1023, 1023, 0, rgb_of(16'hFFFF, 16'h0000, 16'h1000));
    queue_beat(1023, 1023, 1, rgb_of(16'h0FFF, 16'h0001, 16'h0004));
    queue_beat(1023, 1023, 2, rgb_of(16'h0000, 16'hFFFF, 16'h0FFF));
    queue_beat(5, 7, 0, rgb_of(16'h0FFF, 16'h0001, 16'h0004));
    queue_beat(5, 7, 3, rgb_of(16'h1000, 16'h0100, 16'h0010));
    queue_beat(0, 1023, 0, rgb_of(16'h0001, 16'h0002, 16'h0003));
    queue_beat(1023, 0, 0, rgb_of(16'h8000, 16'h4000, 16'h2000));
    queue_beat(256, 0, 0, rgb_of(16'h1234, 16'h5678, 16'h9ABC));
    queue_beat(0, 0, COUNT_MAX, rgb_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_beat(256, 0, 7, rgb_of(16'h0000, 16'h0000, 16'h0000));
    queue_beat(1023, 0, COUNT_MAX, rgb_of(16'hAAAA, 16'h5555, 16'hFFFF));
    queue_beat(5, 7, 1, rgb_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
    wait_for_results();

    // random phases over several widths, out-of-range ones included
    for (int p = 0; p < 7; p++) begin
      write_width(widths[p]);
      @(posedge clk);
      idle_on = (p != 2) && (p != 6);
      queue_random(BEATS_PER_WIDTH);
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_pixels.size()));
    $display("summary: %0d sample beats, %0d results checked, %0d width settings, %0d errors",
             beats_accepted, results_checked, widths_seen + 1, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/core/ppag_pkg.sv
rtl/core/ppag_store.sv
rtl/core/ppag_divider.sv
rtl/core/ppag_gamma.sv
rtl/core/progressive_pixel_average_gamma_pack_core.sv
test/tb_top.sv
